[hdl/gdb_pkg.sv]
// Shared types, widths and calendar tables for the Gregorian day-count block.
// No dependencies; imported by gregorian_days_between.
`timescale 1ns / 1ps

package gdb_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int COUNT_W  = 22;
   localparam int SERIAL_W = 23;   // serial day number of any 14-bit year
   localparam int DOY_W    = 9;    // day of year, up to 366
   localparam int Q4_W     = YEAR_W - 2;
   localparam int Q100_W   = 8;    // largest 14-bit year / 100 is 163
   localparam int Q400_W   = Q100_W - 2;

   localparam int MAX_YEAR = 9999;

   // floor(x / 25) = (x * DIV25_MUL) >> DIV25_SHIFT for any x below 4096
   localparam int DIV25_MUL   = 2622;
   localparam int DIV25_SHIFT = 16;
   localparam int DIV25_PROD_W = 2 * Q4_W;

   localparam int DAYS_PER_YEAR = 365;

   localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

   localparam logic [DAY_W-1:0] FEB_LEAP_LEN   = DAY_W'(29);
   localparam logic [DAY_W-1:0] FEB_COMMON_LEN = DAY_W'(28);

   typedef struct packed {
      logic [YEAR_W-1:0]  start_year;
      logic [MONTH_W-1:0] start_month;
      logic [DAY_W-1:0]   start_day;
      logic [YEAR_W-1:0]  end_year;
      logic [MONTH_W-1:0] end_month;
      logic [DAY_W-1:0]   end_day;
      logic               include_end_day;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] day_count;
      logic               invalid_date;
   } rsp_type;

   // Length of a month in a common year; zero for a code that is no month.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1:    len = 5'd31;
         4'd2:    len = 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // Days in the months before month m of a common year.
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] cum;
      case (m)
         4'd1:    cum = 9'd0;
         4'd2:    cum = 9'd31;
         4'd3:    cum = 9'd59;
         4'd4:    cum = 9'd90;
         4'd5:    cum = 9'd120;
         4'd6:    cum = 9'd151;
         4'd7:    cum = 9'd181;
         4'd8:    cum = 9'd212;
         4'd9:    cum = 9'd243;
         4'd10:   cum = 9'd273;
         4'd11:   cum = 9'd304;
         4'd12:   cum = 9'd334;
         default: cum = 9'd0;
      endcase
      return cum;
   endfunction

endpackage

[hdl/gregorian_days_between.sv]
// Gregorian day count between two dates, four-stage pipeline.
// Depends on gdb_pkg for the beat types, widths and month tables.
`timescale 1ns / 1ps

// Usage
//   req channel: one beat carries a start date, an end date and the
//   include_end_day flag. A beat is taken on a rising clock edge with
//   req_valid high and req_stall low.
//   rsp channel: one beat per request, in request order, carrying day_count
//   and invalid_date; taken on an edge with rsp_valid high and rsp_stall low.
//   A beat passes the stage 1, 2 and 3 registers and then the response
//   register, which drives rsp_valid and rsp_data.
//   Throughput: 1 beat per cycle while rsp_stall is low; each stage is one
//   register deep, and stage 1 holds the 12 x 12 reciprocal multiply that
//   divides the year by 100.
//   A bad year, month or day on either date returns invalid_date = 1 and a
//   count of 0. A start not before the end returns include_end_day as the count.
//   Reset clears every stage valid bit and the response valid; payload
//   registers are not reset. When rsp_stall holds, the full stages hold their
//   beats, empty stages keep filling, and req_stall rises once the pipe is full.
module gregorian_days_between
   import gdb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // ---------------------------------------------------------------
   // Flow control: a stage advances when the next one is empty or moving.
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic adv1, adv2, adv3, adv4;

   assign adv4      = !rsp_valid_ff || !rsp_stall;
   assign adv3      = !v3_ff || adv4;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= req_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
         if (adv4) begin
            rsp_valid_ff <= v3_ff;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: range checks and year / 100 by reciprocal multiply.
   // Index 0 is the start date, index 1 the end date.
   // ---------------------------------------------------------------
   logic [YEAR_W-1:0]  y1_in [2];
   logic [MONTH_W-1:0] m1_in [2];
   logic [DAY_W-1:0]   d1_in [2];
   logic [Q100_W-1:0]  q100y1_in [2];
   logic               ok1_in [2];

   logic [YEAR_W-1:0]  y1_ff [2];
   logic [MONTH_W-1:0] m1_ff [2];
   logic [DAY_W-1:0]   d1_ff [2];
   logic [Q100_W-1:0]  q100y1_ff [2];
   logic               ok1_ff [2];
   logic               inc1_ff;

   always_comb begin
      logic [DIV25_PROD_W-1:0] prod;
      y1_in[0] = req_data.start_year;
      m1_in[0] = req_data.start_month;
      d1_in[0] = req_data.start_day;
      y1_in[1] = req_data.end_year;
      m1_in[1] = req_data.end_month;
      d1_in[1] = req_data.end_day;
      prod     = '0;
      for (int i = 0; i < 2; i++) begin
         // floor(y / 100) = floor(floor(y / 4) / 25)
         prod = DIV25_PROD_W'(y1_in[i][YEAR_W-1:2]) * DIV25_PROD_W'(DIV25_MUL);
         q100y1_in[i] = prod[DIV25_SHIFT +: Q100_W];
         ok1_in[i] = (y1_in[i] != '0) && (y1_in[i] <= YEAR_W'(MAX_YEAR))
                  && (m1_in[i] >= MONTH_JAN) && (m1_in[i] <= MONTH_DEC)
                  && (d1_in[i] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         y1_ff     <= y1_in;
         m1_ff     <= m1_in;
         d1_ff     <= d1_in;
         q100y1_ff <= q100y1_in;
         ok1_ff    <= ok1_in;
         inc1_ff   <= req_data.include_end_day;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: leap rule, month length check, day of year, and the
   // quotients of (year - 1) by 4, 100 and 400.
   // ---------------------------------------------------------------
   logic [YEAR_W-1:0] py2_in [2];
   logic [Q4_W-1:0]   q4_2_in [2];
   logic [Q100_W-1:0] q100_2_in [2];
   logic [Q400_W-1:0] q400_2_in [2];
   logic [DOY_W-1:0]  doy2_in [2];
   logic              ok2_in [2];

   logic [YEAR_W-1:0] py2_ff [2];
   logic [Q4_W-1:0]   q4_2_ff [2];
   logic [Q100_W-1:0] q100_2_ff [2];
   logic [Q400_W-1:0] q400_2_ff [2];
   logic [DOY_W-1:0]  doy2_ff [2];
   logic              ok2_ff [2];
   logic              inc2_ff;

   always_comb begin
      logic             div4, div100, div400, leap;
      logic [Q4_W-1:0]  back25;
      logic [DAY_W-1:0] len;
      div4 = 1'b0;
      div100 = 1'b0;
      div400 = 1'b0;
      leap = 1'b0;
      back25 = '0;
      len = '0;
      for (int i = 0; i < 2; i++) begin
         back25 = Q4_W'(q100y1_ff[i]) * Q4_W'(25);
         div4   = (y1_ff[i][1:0] == 2'b00);
         div100 = div4 && (back25 == y1_ff[i][YEAR_W-1:2]);
         div400 = div100 && (q100y1_ff[i][1:0] == 2'b00);
         leap   = (div4 && !div100) || div400;

         if (m1_ff[i] == MONTH_FEB) begin
            len = leap ? FEB_LEAP_LEN : FEB_COMMON_LEN;
         end else begin
            len = month_len(m1_ff[i]);
         end
         ok2_in[i] = ok1_ff[i] && (d1_ff[i] <= len);

         doy2_in[i] = days_before(m1_ff[i]) + DOY_W'(d1_ff[i])
                    + DOY_W'(leap && (m1_ff[i] > MONTH_FEB));

         // floor((y - 1) / n) drops by one exactly when n divides y
         py2_in[i]    = y1_ff[i] - YEAR_W'(1);
         q4_2_in[i]   = y1_ff[i][YEAR_W-1:2] - Q4_W'(div4);
         q100_2_in[i] = q100y1_ff[i] - Q100_W'(div100);
         q400_2_in[i] = q100y1_ff[i][Q100_W-1:2] - Q400_W'(div400);
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         py2_ff    <= py2_in;
         q4_2_ff   <= q4_2_in;
         q100_2_ff <= q100_2_in;
         q400_2_ff <= q400_2_in;
         doy2_ff   <= doy2_in;
         ok2_ff    <= ok2_in;
         inc2_ff   <= inc1_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: serial day number of each date.
   // ---------------------------------------------------------------
   logic [SERIAL_W-1:0] ser3_in [2];
   logic [SERIAL_W-1:0] ser3_ff [2];
   logic                ok3_ff;
   logic                inc3_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         ser3_in[i] = SERIAL_W'(py2_ff[i]) * SERIAL_W'(DAYS_PER_YEAR)
                    + SERIAL_W'(q4_2_ff[i]) - SERIAL_W'(q100_2_ff[i])
                    + SERIAL_W'(q400_2_ff[i]) + SERIAL_W'(doy2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         ser3_ff <= ser3_in;
         ok3_ff  <= ok2_ff[0] && ok2_ff[1];
         inc3_ff <= inc2_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: difference, end-day option, saturation, response register.
   // ---------------------------------------------------------------
   rsp_type             rsp_in;
   rsp_type             rsp_ff;
   logic [SERIAL_W-1:0] diff;
   logic [SERIAL_W:0]   total;

   always_comb begin
      diff  = (ser3_ff[0] < ser3_ff[1]) ? (ser3_ff[1] - ser3_ff[0]) : '0;
      total = (SERIAL_W + 1)'(diff) + (SERIAL_W + 1)'(inc3_ff);
      if (!ok3_ff) begin
         rsp_in.day_count    = '0;
         rsp_in.invalid_date = 1'b1;
      end else begin
         // clamp at the largest 22-bit count
         if (total[SERIAL_W:COUNT_W] != '0) begin
            rsp_in.day_count = '1;
         end else begin
            rsp_in.day_count = total[COUNT_W-1:0];
         end
         rsp_in.invalid_date = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
